@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the window color classifier.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clk edge, disabled while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check on every rising clk edge, also during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/wrgb_pkg.sv @@
// Types, constants and helper functions of the window RGB dominant color block.
// No dependencies; used by wrgb_accum and window_rgb_dominant_color.
package wrgb_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W  = 8;
    localparam int DIM_W  = 13;
    localparam int SUM_W  = 29;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int IDX_W  = 2;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 96;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(64);
    localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(64);

    // floor(x / 3) as (x * RECIP3) >> RECIP3_SH, exact for x below 2^17.
    localparam int RECIP3_SH = 17;
    localparam logic [RECIP3_SH-1:0] RECIP3 = RECIP3_SH'(43691);

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);

    typedef enum logic [1:0] {
        CLASS_RED   = 2'd0,
        CLASS_GREEN = 2'd1,
        CLASS_BLUE  = 2'd2,
        CLASS_NONE  = 2'd3
    } color_class_t;

    // Totals of one finished frame, waiting for the output register.
    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } frame_sum_t;

    // A size of zero acts as one, and a size above the maximum as the maximum.
    function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > maxv)
            r = maxv;
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] div3(input logic [DIM_W:0] x);
        logic [DIM_W+RECIP3_SH:0] p;
        p = (DIM_W+RECIP3_SH+1)'(x) * (DIM_W+RECIP3_SH+1)'(RECIP3);
        return p[RECIP3_SH +: DIM_W];
    endfunction

    function automatic logic [DIM_W-1:0] three_quarters(input logic [DIM_W-1:0] x);
        logic [DIM_W+1:0] t;
        t = {1'b0, x, 1'b0} + {2'b00, x};
        return t[DIM_W+1:2];
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                 input logic [PIX_W-1:0] v);
        logic [SUM_W:0] s;
        s = {1'b0, acc} + (SUM_W+1)'(v);
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function automatic logic dominates(input logic [SUM_W-1:0] a,
                                       input logic [SUM_W-1:0] b,
                                       input logic [SUM_W-1:0] c);
        logic [SUM_W+1:0] b3;
        logic [SUM_W+1:0] c3;
        b3 = {1'b0, b, 1'b0} + {2'b00, b};
        c3 = {1'b0, c, 1'b0} + {2'b00, c};
        return ({2'b00, a} > b3) && ({2'b00, a} > c3);
    endfunction

endpackage

@@ rtl/wrgb_accum.sv @@
// Frame size registers, pixel position tracking and window accumulators.
// Depends on wrgb_pkg; instantiated by window_rgb_dominant_color.
module wrgb_accum (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [wrgb_pkg::IDX_W-1:0]        cfg_index,
    input  logic [wrgb_pkg::DIM_W-1:0]        cfg_data,
    input  logic                              pix_valid,
    output logic                              pix_ready,
    input  logic [wrgb_pkg::PIX_W-1:0]        pix_red,
    input  logic [wrgb_pkg::PIX_W-1:0]        pix_green,
    input  logic [wrgb_pkg::PIX_W-1:0]        pix_blue,
    output wrgb_pkg::frame_sum_t              done,
    input  logic                              done_pop
);

    logic [wrgb_pkg::DIM_W-1:0] width_reg, height_reg;
    logic [wrgb_pkg::DIM_W-1:0] col_lo_reg, col_hi_reg, row_lo_reg, row_hi_reg;
    logic [wrgb_pkg::DIM_W-1:0] cfg_eff_w, cfg_eff_h;

    logic [wrgb_pkg::COL_W-1:0] col_reg, col_next;
    logic [wrgb_pkg::ROW_W-1:0] row_reg, row_next;
    logic [wrgb_pkg::SUM_W-1:0] acc_red_reg, acc_green_reg, acc_blue_reg;
    logic [wrgb_pkg::SUM_W-1:0] acc_red_next, acc_green_next, acc_blue_next;
    wrgb_pkg::frame_sum_t       done_reg;

    logic accept, in_window, row_end, frame_end;
    logic [wrgb_pkg::DIM_W:0] col_ext, row_ext;

    assign cfg_eff_w = wrgb_pkg::eff_size(cfg_data, wrgb_pkg::DIM_W'(wrgb_pkg::MAX_WIDTH));
    assign cfg_eff_h = wrgb_pkg::eff_size(cfg_data, wrgb_pkg::DIM_W'(wrgb_pkg::MAX_HEIGHT));

    // The window bounds are worked out at reset and when a size register is written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= wrgb_pkg::RESET_WIDTH;
            height_reg <= wrgb_pkg::RESET_HEIGHT;
            col_lo_reg <= wrgb_pkg::div3({1'b0, wrgb_pkg::RESET_WIDTH});
            col_hi_reg <= wrgb_pkg::div3({wrgb_pkg::RESET_WIDTH, 1'b0});
            row_lo_reg <= wrgb_pkg::RESET_HEIGHT >> 1;
            row_hi_reg <= wrgb_pkg::three_quarters(wrgb_pkg::RESET_HEIGHT);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wrgb_pkg::REG_FRAME_WIDTH:
                begin
                    width_reg  <= cfg_eff_w;
                    col_lo_reg <= wrgb_pkg::div3({1'b0, cfg_eff_w});
                    col_hi_reg <= wrgb_pkg::div3({cfg_eff_w, 1'b0});
                end
                wrgb_pkg::REG_FRAME_HEIGHT:
                begin
                    height_reg <= cfg_eff_h;
                    row_lo_reg <= cfg_eff_h >> 1;
                    row_hi_reg <= wrgb_pkg::three_quarters(cfg_eff_h);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign pix_ready = !done_reg.valid || done_pop;
    assign accept    = pix_valid && pix_ready;

    assign col_ext = (wrgb_pkg::DIM_W+1)'(col_reg);
    assign row_ext = (wrgb_pkg::DIM_W+1)'(row_reg);

    assign in_window = (col_ext >= {1'b0, col_lo_reg}) && (col_ext < {1'b0, col_hi_reg}) &&
                       (row_ext >= {1'b0, row_lo_reg}) && (row_ext < {1'b0, row_hi_reg});

    // A position left past the end by a smaller new size still ends the row or frame.
    assign row_end   = (col_ext + (wrgb_pkg::DIM_W+1)'(1)) >= {1'b0, width_reg};
    assign frame_end = row_end &&
                       ((row_ext + (wrgb_pkg::DIM_W+1)'(1)) >= {1'b0, height_reg});

    always_comb
    begin
        col_next = col_reg + wrgb_pkg::COL_W'(1);
        row_next = row_reg;
        if (row_end)
        begin
            col_next = '0;
            row_next = frame_end ? '0 : row_reg + wrgb_pkg::ROW_W'(1);
        end
    end

    always_comb
    begin
        acc_red_next   = acc_red_reg;
        acc_green_next = acc_green_reg;
        acc_blue_next  = acc_blue_reg;
        if (in_window)
        begin
            acc_red_next   = wrgb_pkg::sat_add(acc_red_reg, pix_red);
            acc_green_next = wrgb_pkg::sat_add(acc_green_reg, pix_green);
            acc_blue_next  = wrgb_pkg::sat_add(acc_blue_reg, pix_blue);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            acc_red_reg   <= '0;
            acc_green_reg <= '0;
            acc_blue_reg  <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (frame_end)
            begin
                acc_red_reg   <= '0;
                acc_green_reg <= '0;
                acc_blue_reg  <= '0;
            end
            else
            begin
                acc_red_reg   <= acc_red_next;
                acc_green_reg <= acc_green_next;
                acc_blue_reg  <= acc_blue_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= '0;
        else if (accept && frame_end)
        begin
            done_reg.valid <= 1'b1;
            done_reg.red   <= acc_red_next;
            done_reg.green <= acc_green_next;
            done_reg.blue  <= acc_blue_next;
        end
        else if (done_pop)
            done_reg.valid <= 1'b0;
    end

    assign done = done_reg;

endmodule

@@ rtl/window_rgb_dominant_color.sv @@
// Top level of the window RGB dominant color classifier: output stage and checks.
// Depends on wrgb_pkg, wrgb_accum and assert_macros.svh.
//
// Usage: pixels enter in row-major order on the s_ stream, one word per pixel.
// The block sums red, green and blue over the window of columns [W/3, 2W/3)
// and rows [H/2, 3H/4) and, after the last pixel of a frame, sends one word
// on the m_ stream with the dominant class and the three window totals.
// Frame width and height are written on the cfg_ port while no frame is in
// flight; a write takes effect at the next clock edge.
// Throughput: one pixel per cycle while s_tready is high. The accumulators add in the same cycle a
// pixel is accepted, so nothing but the output registers limits the rate.
// Result path: the totals of a frame register in wrgb_accum at the edge that
// accepts its last pixel; the class compare then loads them into the output
// register once that register is free, and the result word is valid there.
// Stall: while m_tready is low a pending result holds; the totals of one more
// finished frame can wait behind it, and while they wait s_tready stays low
// until the output register frees up.
// Reset: rst_n clears position, sums and valid flags at once and restores
// the 64 by 64 frame size.
`include "assert_macros.svh"

module window_rgb_dominant_color (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [wrgb_pkg::IDX_W-1:0]             cfg_index,
    input  logic [wrgb_pkg::DIM_W-1:0]             cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // pix_red [7:0], pix_green [15:8], pix_blue [23:16]
    input  logic [wrgb_pkg::IN_TDATA_W-1:0]        s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // blob_class [1:0], sum_red [30:2], sum_green [59:31], sum_blue [88:60], zero [95:89]
    output logic [wrgb_pkg::OUT_TDATA_W-1:0]       m_tdata
);

    wrgb_pkg::frame_sum_t       done;
    logic                       advance, done_pop;
    logic                       m_tvalid_reg;
    wrgb_pkg::color_class_t     class_next, class_reg;
    logic [wrgb_pkg::SUM_W-1:0] sum_red_reg, sum_green_reg, sum_blue_reg;

    wrgb_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (s_tvalid),
        .pix_ready (s_tready),
        .pix_red   (s_tdata[7:0]),
        .pix_green (s_tdata[15:8]),
        .pix_blue  (s_tdata[23:16]),
        .done      (done),
        .done_pop  (done_pop)
    );

    assign advance  = !m_tvalid_reg || m_tready;
    assign done_pop = advance && done.valid;

    // Red is tested first, then green, then blue.
    always_comb
    begin
        if (wrgb_pkg::dominates(done.red, done.green, done.blue))
            class_next = wrgb_pkg::CLASS_RED;
        else if (wrgb_pkg::dominates(done.green, done.red, done.blue))
            class_next = wrgb_pkg::CLASS_GREEN;
        else if (wrgb_pkg::dominates(done.blue, done.red, done.green))
            class_next = wrgb_pkg::CLASS_BLUE;
        else
            class_next = wrgb_pkg::CLASS_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (advance)
            m_tvalid_reg <= done.valid;
    end

    always_ff @(posedge clk)
    begin
        if (done_pop)
        begin
            class_reg     <= class_next;
            sum_red_reg   <= done.red;
            sum_green_reg <= done.green;
            sum_blue_reg  <= done.blue;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, sum_blue_reg, sum_green_reg, sum_red_reg, class_reg};

    `ASSERT_CLK(a_stall_only_when_full, !s_tready |-> (done.valid && m_tvalid_reg && !m_tready),
                "input stalled without a blocked result")
    `ASSERT_CLK(a_result_from_totals, $rose(m_tvalid) |-> $past(done.valid),
                "result appeared without finished frame totals")
    `ASSERT_CLK(a_totals_held, (done.valid && !advance) |=> done.valid,
                "frame totals lost while the output was stalled")

endmodule
